### rtl/dma_list_and_block_sequencer_defines.svh
// Assertion macros shared by the sequencer RTL.
`ifndef DMA_LIST_AND_BLOCK_SEQUENCER_DEFINES_SVH
`define DMA_LIST_AND_BLOCK_SEQUENCER_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, cond, expr)
`define ASSERT_NEXT(label, clk, rst, cond, expr)
`endif

`endif

### rtl/dmaseq_pkg.sv
package dmaseq_pkg;

   localparam int ADDR_BITS = 21;
   localparam int COUNT_BITS = 24;
   localparam int WORD_BITS = 32;
   localparam int HDR_COUNT_LSB = 24;
   localparam int HDR_END_BIT = 23;

   typedef logic [ADDR_BITS-1:0] addr_type;
   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [WORD_BITS-1:0] word_type;

   localparam addr_type WORD_MASK = ~addr_type'(3);
   localparam addr_type ADDR_STEP = addr_type'(4);
   localparam word_type OT_END_WORD = word_type'(32'h00FF_FFFF);

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_DATA  = 2'd1,
      OP_TICK  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      MODE_BLOCK = 2'd0,
      MODE_OT    = 2'd1,
      MODE_LIST  = 2'd2
   } mode_type;

   typedef enum logic [3:0] {
      PH_IDLE    = 4'b0001,
      PH_WORD    = 4'b0010,
      PH_HEADER  = 4'b0100,
      PH_OTWRITE = 4'b1000
   } phase_type;

   typedef struct packed {
      logic     read_valid;
      addr_type read_addr;
      logic     write_valid;
      addr_type write_addr;
      word_type write_data;
      logic     gpu_valid;
      word_type gpu_word;
      logic     done_res;
      logic     busy_res;
   } rsp_type;

endpackage

### rtl/dma_list_and_block_sequencer.sv
// A transaction in the input register is sequenced into the result register. Throughput:
// one transaction per cycle unless rsp_stall holds the result register; the input and
// result registers each hold one transaction, and all sequencing is a single pass between them.
// Reset: synchronous, active high; clears the sequencer to idle and empties
// both registers.
`include "dma_list_and_block_sequencer_defines.svh"

module dma_list_and_block_sequencer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_op,
   input  logic [1:0]                    req_mode,
   input  logic                          req_step_down,
   input  logic [dmaseq_pkg::ADDR_BITS-1:0]  req_base_addr,
   input  logic [dmaseq_pkg::COUNT_BITS-1:0] req_word_count,
   input  logic [dmaseq_pkg::WORD_BITS-1:0]  req_read_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_read_valid,
   output logic [dmaseq_pkg::ADDR_BITS-1:0]  rsp_read_addr,
   output logic                          rsp_write_valid,
   output logic [dmaseq_pkg::ADDR_BITS-1:0]  rsp_write_addr,
   output logic [dmaseq_pkg::WORD_BITS-1:0]  rsp_write_data,
   output logic                          rsp_gpu_valid,
   output logic [dmaseq_pkg::WORD_BITS-1:0]  rsp_gpu_word,
   output logic                          rsp_done_res,
   output logic                          rsp_busy_res
);

   // input register
   logic                   in_valid_ff, in_valid_in;
   logic [1:0]             op_ff;
   logic [1:0]             mode_ff;
   logic                   down_ff;
   dmaseq_pkg::addr_type   base_ff;
   dmaseq_pkg::count_type  count_ff;
   dmaseq_pkg::word_type   data_ff;

   // sequencer state
   dmaseq_pkg::phase_type  phase_ff, phase_in;
   logic [1:0]             act_mode_ff, act_mode_in;
   dmaseq_pkg::addr_type   cur_ff, cur_in;
   dmaseq_pkg::count_type  left_ff, left_in;
   logic                   going_down_ff, going_down_in;
   logic                   end_seen_ff, end_seen_in;
   dmaseq_pkg::addr_type   next_hdr_ff, next_hdr_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   dmaseq_pkg::rsp_type    rsp_ff, rsp_in;

   logic                   in_load;
   logic                   out_free;
   logic                   do_proc;
   logic                   was_busy;
   logic                   tick_hit;

   logic                   ot_start;
   dmaseq_pkg::addr_type   ot_cur;
   dmaseq_pkg::count_type  ot_left;
   logic                   ot_down;
   dmaseq_pkg::addr_type   ot_prev;
   dmaseq_pkg::addr_type   ot_next;
   dmaseq_pkg::count_type  ot_left_dec;

   dmaseq_pkg::addr_type   blk_next;
   dmaseq_pkg::addr_type   list_next;
   dmaseq_pkg::count_type  left_dec;
   dmaseq_pkg::count_type  hdr_count;
   dmaseq_pkg::addr_type   hdr_addr;
   logic                   hdr_end;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign do_proc   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign in_load   = req_valid && !req_stall;

   assign in_valid_in  = in_load ? 1'b1 : (do_proc ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = do_proc ? 1'b1 : (out_free ? 1'b0 : rsp_valid_ff);

   // ordering-table write, shared by start and tick
   assign ot_start    = (op_ff == dmaseq_pkg::OP_START);
   assign ot_cur      = ot_start ? base_ff : cur_ff;
   assign ot_left     = ot_start ? count_ff : left_ff;
   assign ot_down     = ot_start ? down_ff : going_down_ff;
   assign ot_prev     = ot_cur - dmaseq_pkg::ADDR_STEP;
   assign ot_next     = ot_down ? ot_prev : ot_cur + dmaseq_pkg::ADDR_STEP;
   assign ot_left_dec = ot_left - dmaseq_pkg::count_type'(1);

   assign blk_next  = going_down_ff ? cur_ff - dmaseq_pkg::ADDR_STEP
                                    : cur_ff + dmaseq_pkg::ADDR_STEP;
   assign list_next = (cur_ff + dmaseq_pkg::ADDR_STEP) & dmaseq_pkg::WORD_MASK;
   assign left_dec  = left_ff - dmaseq_pkg::count_type'(1);

   assign hdr_count = dmaseq_pkg::count_type'(data_ff[dmaseq_pkg::WORD_BITS-1:
                                                      dmaseq_pkg::HDR_COUNT_LSB]);
   assign hdr_addr  = data_ff[dmaseq_pkg::ADDR_BITS-1:0] & dmaseq_pkg::WORD_MASK;
   assign hdr_end   = data_ff[dmaseq_pkg::HDR_END_BIT];

   assign was_busy = (phase_ff != dmaseq_pkg::PH_IDLE);
   assign tick_hit = do_proc && (op_ff == dmaseq_pkg::OP_TICK)
                     && (phase_ff == dmaseq_pkg::PH_OTWRITE);

   always_comb begin
      phase_in      = phase_ff;
      act_mode_in   = act_mode_ff;
      cur_in        = cur_ff;
      left_in       = left_ff;
      going_down_in = going_down_ff;
      end_seen_in   = end_seen_ff;
      next_hdr_in   = next_hdr_ff;
      rsp_in        = rsp_ff;
      if (do_proc) begin
         rsp_in = '0;
         case (op_ff)
            dmaseq_pkg::OP_START: begin
               if (!was_busy) begin
                  case (mode_ff)
                     dmaseq_pkg::MODE_BLOCK, dmaseq_pkg::MODE_OT: begin
                        act_mode_in   = mode_ff;
                        cur_in        = base_ff;
                        going_down_in = down_ff;
                        if (count_ff == '0) begin
                           left_in         = '0;
                           rsp_in.done_res = 1'b1;
                        end else if (mode_ff == dmaseq_pkg::MODE_BLOCK) begin
                           left_in           = count_ff;
                           phase_in          = dmaseq_pkg::PH_WORD;
                           rsp_in.read_valid = 1'b1;
                           rsp_in.read_addr  = base_ff & dmaseq_pkg::WORD_MASK;
                        end else begin
                           rsp_in.write_valid = 1'b1;
                           rsp_in.write_addr  = ot_cur & dmaseq_pkg::WORD_MASK;
                           rsp_in.write_data  = (ot_left == dmaseq_pkg::count_type'(1))
                                                ? dmaseq_pkg::OT_END_WORD
                                                : dmaseq_pkg::word_type'(ot_prev);
                           left_in  = ot_left_dec;
                           cur_in   = ot_next;
                           phase_in = (ot_left_dec == '0) ? dmaseq_pkg::PH_IDLE
                                                          : dmaseq_pkg::PH_OTWRITE;
                           // single-entry table finishes with its start
                           rsp_in.done_res = (ot_left_dec == '0);
                        end
                     end
                     dmaseq_pkg::MODE_LIST: begin
                        act_mode_in       = mode_ff;
                        going_down_in     = down_ff;
                        cur_in            = base_ff & dmaseq_pkg::WORD_MASK;
                        end_seen_in       = 1'b0;
                        phase_in          = dmaseq_pkg::PH_HEADER;
                        rsp_in.read_valid = 1'b1;
                        rsp_in.read_addr  = base_ff & dmaseq_pkg::WORD_MASK;
                     end
                     default: ;
                  endcase
               end
            end
            dmaseq_pkg::OP_DATA: begin
               case (phase_ff)
                  dmaseq_pkg::PH_HEADER: begin
                     end_seen_in = hdr_end;
                     next_hdr_in = hdr_addr;
                     left_in     = hdr_count;
                     if (hdr_count != '0) begin
                        cur_in            = list_next;
                        phase_in          = dmaseq_pkg::PH_WORD;
                        rsp_in.read_valid = 1'b1;
                        rsp_in.read_addr  = list_next;
                     end else if (hdr_end) begin
                        phase_in = dmaseq_pkg::PH_IDLE;
                     end else begin
                        cur_in            = hdr_addr;
                        rsp_in.read_valid = 1'b1;
                        rsp_in.read_addr  = hdr_addr;
                     end
                  end
                  dmaseq_pkg::PH_WORD: begin
                     rsp_in.gpu_valid = 1'b1;
                     rsp_in.gpu_word  = data_ff;
                     left_in          = left_dec;
                     if (act_mode_ff == dmaseq_pkg::MODE_LIST) begin
                        if (left_dec != '0) begin
                           cur_in            = list_next;
                           rsp_in.read_valid = 1'b1;
                           rsp_in.read_addr  = list_next;
                        end else if (end_seen_ff) begin
                           phase_in = dmaseq_pkg::PH_IDLE;
                        end else begin
                           cur_in            = next_hdr_ff;
                           phase_in          = dmaseq_pkg::PH_HEADER;
                           rsp_in.read_valid = 1'b1;
                           rsp_in.read_addr  = next_hdr_ff;
                        end
                     end else begin
                        cur_in = blk_next;
                        if (left_dec == '0) begin
                           phase_in = dmaseq_pkg::PH_IDLE;
                        end else begin
                           rsp_in.read_valid = 1'b1;
                           rsp_in.read_addr  = blk_next & dmaseq_pkg::WORD_MASK;
                        end
                     end
                  end
                  default: ;
               endcase
            end
            dmaseq_pkg::OP_TICK: begin
               if (phase_ff == dmaseq_pkg::PH_OTWRITE) begin
                  rsp_in.write_valid = 1'b1;
                  rsp_in.write_addr  = ot_cur & dmaseq_pkg::WORD_MASK;
                  rsp_in.write_data  = (ot_left == dmaseq_pkg::count_type'(1))
                                       ? dmaseq_pkg::OT_END_WORD
                                       : dmaseq_pkg::word_type'(ot_prev);
                  left_in = ot_left_dec;
                  cur_in  = ot_next;
                  if (ot_left_dec == '0) begin
                     phase_in = dmaseq_pkg::PH_IDLE;
                  end
               end
            end
            default: ;
         endcase
         if (was_busy && phase_in == dmaseq_pkg::PH_IDLE) begin
            rsp_in.done_res = 1'b1;
         end
         rsp_in.busy_res = (phase_in != dmaseq_pkg::PH_IDLE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         phase_ff      <= dmaseq_pkg::PH_IDLE;
         act_mode_ff   <= '0;
         cur_ff        <= '0;
         left_ff       <= '0;
         going_down_ff <= 1'b0;
         end_seen_ff   <= 1'b0;
         next_hdr_ff   <= '0;
      end else begin
         in_valid_ff   <= in_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         phase_ff      <= phase_in;
         act_mode_ff   <= act_mode_in;
         cur_ff        <= cur_in;
         left_ff       <= left_in;
         going_down_ff <= going_down_in;
         end_seen_ff   <= end_seen_in;
         next_hdr_ff   <= next_hdr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         op_ff    <= req_op;
         mode_ff  <= req_mode;
         down_ff  <= req_step_down;
         base_ff  <= req_base_addr;
         count_ff <= req_word_count;
         data_ff  <= req_read_data;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_valid  = rsp_ff.read_valid;
   assign rsp_read_addr   = rsp_ff.read_addr;
   assign rsp_write_valid = rsp_ff.write_valid;
   assign rsp_write_addr  = rsp_ff.write_addr;
   assign rsp_write_data  = rsp_ff.write_data;
   assign rsp_gpu_valid   = rsp_ff.gpu_valid;
   assign rsp_gpu_word    = rsp_ff.gpu_word;
   assign rsp_done_res    = rsp_ff.done_res;
   assign rsp_busy_res    = rsp_ff.busy_res;

   `ASSERT_IMPLY(a_busy_tracks_phase, clock, reset, rsp_valid_ff, rsp_ff.busy_res == was_busy)
   `ASSERT_IMPLY(a_done_not_busy, clock, reset, rsp_valid_ff, !(rsp_ff.done_res && rsp_ff.busy_res))
   `ASSERT_IMPLY(a_one_ram_access, clock, reset, rsp_valid_ff, !(rsp_ff.read_valid && rsp_ff.write_valid))
   `ASSERT_IMPLY(a_ot_count_live, clock, reset, phase_ff == dmaseq_pkg::PH_OTWRITE, left_ff != '0)
   `ASSERT_NEXT(a_tick_writes, clock, reset, tick_hit, rsp_valid_ff && rsp_ff.write_valid)

endmodule
